FILE: sv/svdc_pkg.sv
// Shared constants, types and coefficient helper for the velocity/density converter.
// Used by svdc_if.sv, seismic_velocity_density_convert.sv and the testbench; no dependencies.
`default_nettype none

package svdc_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int VEL_BITS_DEF  = 14;

  localparam int VALUE_W = 16;
  localparam int FLOOR_W = 12;
  localparam logic [FLOOR_W-1:0] FLOOR_RST = 12'd1000;

  // accumulator: signed, limited to +-2^61
  localparam int ACC_W    = 63;
  localparam int MAG_W    = 62;
  localparam int MAG_LO_W = MAG_W / 2;
  localparam int MAG_HI_W = MAG_W - MAG_LO_W;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic        [MAG_W-1:0] mag_t;

  localparam mag_t ACC_LIM = {1'b1, {(MAG_W-1){1'b0}}};
  localparam acc_t ACC_MAX = acc_t'({1'b0, ACC_LIM});
  localparam acc_t ACC_MIN = -ACC_MAX;

  // request codes
  localparam logic REQ_VP  = 1'b0;
  localparam logic REQ_RHO = 1'b1;

  // Horner steps: acc = c - x*acc for all but the last, acc = c + x*acc for the last
  localparam int NSTEP = 5;
  localparam logic [31:0] VP_MICRO  [NSTEP] =
    '{32'd25100, 32'd268300, 32'd820600, 32'd2094700, 32'd940900};
  localparam logic [31:0] RHO_MICRO [NSTEP] =
    '{32'd4300, 32'd67100, 32'd472100, 32'd1661200, 32'd0};
  localparam logic [31:0] RHO_LEAD_MICRO = 32'd106;

  localparam logic [63:0] MICRO = 64'd1000000;
  localparam logic [9:0]  UNIT_SCALE = 10'd1000;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 16'h7fff;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 16'h8000;

  // coefficient in millionths -> fixed point, rounded half up (elaboration only)
  function automatic acc_t coef_q(input logic [31:0] micro, input int frac);
    logic [63:0] scaled;
    scaled = ({32'd0, micro} << frac) + MICRO / 2;
    return acc_t'(scaled / MICRO);
  endfunction

endpackage

`default_nettype wire

FILE: sv/svdc_if.sv
// Valid/ready channel interfaces for the velocity/density converter.
// Depends on svdc_pkg for widths and defaults.
`default_nettype none

interface svdc_in_if
  import svdc_pkg::*;
#(
  parameter int VEL_BITS = VEL_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [VEL_BITS-1:0] velocity;

  modport source (output valid, output req_type, output velocity, input ready);
  modport sink   (input valid, input req_type, input velocity, output ready);
endinterface

interface svdc_out_if
  import svdc_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      saturated;

  modport source (output valid, output value, output saturated, input ready);
  modport sink   (input valid, input value, input saturated, output ready);
endinterface

`default_nettype wire

FILE: sv/seismic_velocity_density_convert.sv
// Velocity -> P speed / density converter, fully pipelined Horner datapath.
// Throughput: one item per cycle; each stage holds under backpressure, bubbles collapse.
// Each Horner step is five stages: magnitude, partial products, product sum,
// rounding/overflow, coefficient add with clamp.
// Reset (rst_n low, synchronous) clears all valid bits and sets density_floor to 1000.
`default_nettype none

module seismic_velocity_density_convert
  import svdc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int VEL_BITS  = VEL_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  svdc_in_if.sink                 in_ch,
  svdc_out_if.source              out_ch,
  input  wire logic               cfg_we,
  input  wire logic [FLOOR_W-1:0] cfg_wdata
);

  // widths
  localparam int XW  = VEL_BITS + FRAC_BITS - 9;   // speed in km/s, fixed point
  localparam int XL  = (XW + 1) / 2;
  localparam int XH  = XW - XL;
  localparam int PW  = XW + MAG_W;
  localparam int AW  = VEL_BITS - 6;               // velocity / 125
  localparam int TW  = FRAC_BITS - 9;
  localparam int BTW = TW + 7;
  localparam int RW  = MAG_W - FRAC_BITS + 10;

  // velocity * 2^F / 1000 split as (velocity / 125, velocity % 125) against 2^(F-3)
  localparam int DIV_SH = 28;
  localparam logic [21:0] K_A = 22'(((64'd1 << DIV_SH) + 64'd124) / 64'd125);
  localparam logic [63:0] SCALE_POW = 64'd1 << (FRAC_BITS - 3);
  localparam logic [TW-1:0] T_Q = TW'(SCALE_POW / 125);
  localparam logic [6:0]    R_Q = 7'(SCALE_POW % 125);
  localparam int Q_SH = 21;
  localparam logic [14:0] K_Q = 15'(((64'd1 << Q_SH) + 64'd124) / 64'd125);

  localparam acc_t RHO_LEAD = coef_q(RHO_LEAD_MICRO, FRAC_BITS);
  localparam logic signed [63:0] LIM64 = 64'(ACC_MAX);

  // stage map
  localparam int ST_C1    = 0;
  localparam int ST_C2    = 1;
  localparam int ST_C3    = 2;
  localparam int ST_STEP0 = 3;
  localparam int ST_O1    = ST_STEP0 + 5 * NSTEP;
  localparam int ST_O2    = ST_O1 + 1;
  localparam int ST_O3    = ST_O2 + 1;
  localparam int NST      = ST_O3 + 1;

  // ---------------- flow control ----------------
  logic [NST-1:0] v_r;
  logic [NST-1:0] v_nxt;
  logic [NST-1:0] en;

  assign en[NST-1] = !v_r[NST-1] || out_ch.ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  assign v_nxt = {v_r[NST-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
    end
  end

  assign in_ch.ready = en[ST_C1];

  // ---------------- configuration ----------------
  logic [FLOOR_W-1:0] cfg_floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_floor_r <= FLOOR_RST;
    end else if (cfg_we) begin
      cfg_floor_r <= cfg_wdata;
    end
  end

  // ---------------- speed conversion ----------------
  logic                  c1_kind_r;
  logic [VEL_BITS-1:0]   c1_vel_r;
  logic [AW-1:0]         c1_a_r;
  logic [VEL_BITS+21:0]  c1_prod;

  assign c1_prod = (VEL_BITS+22)'(in_ch.velocity) * (VEL_BITS+22)'(K_A);

  always_ff @(posedge clk) begin
    if (en[ST_C1]) begin
      c1_kind_r <= in_ch.req_type;
      c1_vel_r  <= in_ch.velocity;
      c1_a_r    <= c1_prod[DIV_SH +: AW];
    end
  end

  logic                c2_kind_r;
  logic [AW-1:0]       c2_a_r;
  logic [BTW-1:0]      c2_bt_r;
  logic [13:0]         c2_br_r;
  logic [VEL_BITS:0]   c2_a125;
  logic [VEL_BITS-1:0] c2_diff;
  logic [6:0]          c2_rem;

  assign c2_a125 = (VEL_BITS+1)'(c1_a_r) * (VEL_BITS+1)'(7'd125);
  assign c2_diff = c1_vel_r - c2_a125[VEL_BITS-1:0];
  assign c2_rem  = c2_diff[6:0];

  always_ff @(posedge clk) begin
    if (en[ST_C2]) begin
      c2_kind_r <= c1_kind_r;
      c2_a_r    <= c1_a_r;
      c2_bt_r   <= BTW'(c2_rem) * BTW'(T_Q);
      c2_br_r   <= 14'(c2_rem) * 14'(R_Q) + 14'd62;
    end
  end

  logic          c3_kind_r;
  logic [XW-1:0] c3_x_r;
  acc_t          c3_acc_r;
  logic [Q_SH+6:0] c3_qp;
  logic [XW-1:0] c3_x_nxt;

  assign c3_qp    = (Q_SH+7)'(c2_br_r) * (Q_SH+7)'(K_Q);
  assign c3_x_nxt = {c2_a_r, {(FRAC_BITS-3){1'b0}}} + XW'(c2_bt_r) + XW'(c3_qp[Q_SH +: 7]);

  always_ff @(posedge clk) begin
    if (en[ST_C3]) begin
      c3_kind_r <= c2_kind_r;
      c3_x_r    <= c3_x_nxt;
      c3_acc_r  <= (c2_kind_r == REQ_RHO) ? RHO_LEAD : '0;
    end
  end

  // ---------------- Horner steps ----------------
  logic          st_kind [NSTEP+1];
  logic [XW-1:0] st_x    [NSTEP];
  acc_t          st_acc  [NSTEP+1];

  assign st_kind[0] = c3_kind_r;
  assign st_x[0]    = c3_x_r;
  assign st_acc[0]  = c3_acc_r;

  logic                     s1_kind_r [NSTEP];
  logic [XW-1:0]            s1_x_r    [NSTEP];
  logic                     s1_neg_r  [NSTEP];
  mag_t                     s1_mag_r  [NSTEP];
  logic                     s2_kind_r [NSTEP];
  logic [XW-1:0]            s2_x_r    [NSTEP];
  logic                     s2_neg_r  [NSTEP];
  logic [XL+MAG_LO_W-1:0]   s2_pll_r  [NSTEP];
  logic [XL+MAG_HI_W-1:0]   s2_plh_r  [NSTEP];
  logic [XH+MAG_LO_W-1:0]   s2_phl_r  [NSTEP];
  logic [XH+MAG_HI_W-1:0]   s2_phh_r  [NSTEP];
  logic                     s3_kind_r [NSTEP];
  logic [XW-1:0]            s3_x_r    [NSTEP];
  logic                     s3_neg_r  [NSTEP];
  logic [PW-1:0]            s3_prod_r [NSTEP];
  logic                     s4_kind_r [NSTEP];
  logic [XW-1:0]            s4_x_r    [NSTEP];
  logic                     s4_neg_r  [NSTEP];
  mag_t                     s4_mag_r  [NSTEP];
  logic                     s5_kind_r [NSTEP];
  acc_t                     s5_acc_r  [NSTEP];

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    localparam int   B        = ST_STEP0 + 5 * j;
    localparam acc_t C_VP     = coef_q(VP_MICRO[j], FRAC_BITS);
    localparam acc_t C_RHO    = coef_q(RHO_MICRO[j], FRAC_BITS);
    localparam logic SUB_STEP = (j != NSTEP - 1);

    mag_t                  s1_mag_nxt;
    logic [PW-1:0]         s3_prod_nxt;
    logic                  s4_ovf;
    logic [64-FRAC_BITS:0] s4_rnd;
    mag_t                  s4_mag_nxt;
    acc_t                  s5_coef;
    logic signed [63:0]    s5_coef64;
    logic signed [63:0]    s5_term64;
    logic signed [63:0]    s5_sum;
    acc_t                  s5_acc_nxt;

    // magnitude of the running value
    assign s1_mag_nxt = st_acc[j][ACC_W-1] ? MAG_W'(-st_acc[j]) : MAG_W'(st_acc[j]);

    always_ff @(posedge clk) begin
      if (en[B]) begin
        s1_kind_r[j] <= st_kind[j];
        s1_x_r[j]    <= st_x[j];
        s1_neg_r[j]  <= st_acc[j][ACC_W-1];
        s1_mag_r[j]  <= s1_mag_nxt;
      end
    end

    // four partial products of x * |acc|
    always_ff @(posedge clk) begin
      if (en[B+1]) begin
        s2_kind_r[j] <= s1_kind_r[j];
        s2_x_r[j]    <= s1_x_r[j];
        s2_neg_r[j]  <= s1_neg_r[j];
        s2_pll_r[j]  <= (XL+MAG_LO_W)'(s1_x_r[j][XL-1:0])
                      * (XL+MAG_LO_W)'(s1_mag_r[j][MAG_LO_W-1:0]);
        s2_plh_r[j]  <= (XL+MAG_HI_W)'(s1_x_r[j][XL-1:0])
                      * (XL+MAG_HI_W)'(s1_mag_r[j][MAG_W-1:MAG_LO_W]);
        s2_phl_r[j]  <= (XH+MAG_LO_W)'(s1_x_r[j][XW-1:XL])
                      * (XH+MAG_LO_W)'(s1_mag_r[j][MAG_LO_W-1:0]);
        s2_phh_r[j]  <= (XH+MAG_HI_W)'(s1_x_r[j][XW-1:XL])
                      * (XH+MAG_HI_W)'(s1_mag_r[j][MAG_W-1:MAG_LO_W]);
      end
    end

    assign s3_prod_nxt = PW'(s2_pll_r[j])
                       + (PW'(s2_plh_r[j]) << MAG_LO_W)
                       + (PW'(s2_phl_r[j]) << XL)
                       + (PW'(s2_phh_r[j]) << (XL + MAG_LO_W));

    always_ff @(posedge clk) begin
      if (en[B+2]) begin
        s3_kind_r[j] <= s2_kind_r[j];
        s3_x_r[j]    <= s2_x_r[j];
        s3_neg_r[j]  <= s2_neg_r[j];
        s3_prod_r[j] <= s3_prod_nxt;
      end
    end

    // a product past 64 bits clamps; below that the rounded result stays under the limit
    assign s4_ovf     = |s3_prod_r[j][PW-1:64];
    assign s4_rnd     = {1'b0, s3_prod_r[j][63:FRAC_BITS]}
                      + (65-FRAC_BITS)'(s3_prod_r[j][FRAC_BITS-1]);
    assign s4_mag_nxt = s4_ovf ? ACC_LIM : MAG_W'(s4_rnd);

    always_ff @(posedge clk) begin
      if (en[B+3]) begin
        s4_kind_r[j] <= s3_kind_r[j];
        s4_x_r[j]    <= s3_x_r[j];
        s4_neg_r[j]  <= s3_neg_r[j];
        s4_mag_r[j]  <= s4_mag_nxt;
      end
    end

    // coefficient add/subtract with clamp to +-2^61
    assign s5_coef   = (s4_kind_r[j] == REQ_RHO) ? C_RHO : C_VP;
    assign s5_coef64 = 64'(s5_coef);
    assign s5_term64 = $signed({2'b00, s4_mag_r[j]});
    assign s5_sum    = (s4_neg_r[j] ^ SUB_STEP) ? (s5_coef64 - s5_term64)
                                                : (s5_coef64 + s5_term64);
    assign s5_acc_nxt = (s5_sum > LIM64)  ? ACC_MAX :
                        (s5_sum < -LIM64) ? ACC_MIN : ACC_W'(s5_sum);

    always_ff @(posedge clk) begin
      if (en[B+4]) begin
        s5_kind_r[j] <= s4_kind_r[j];
        s5_acc_r[j]  <= s5_acc_nxt;
      end
    end

    assign st_kind[j+1] = s5_kind_r[j];
    assign st_acc[j+1]  = s5_acc_r[j];

    if (j < NSTEP - 1) begin : g_xfwd
      logic [XW-1:0] s5_x_r;
      always_ff @(posedge clk) begin
        if (en[B+4]) begin
          s5_x_r <= s4_x_r[j];
        end
      end
      assign st_x[j+1] = s5_x_r;
    end
  end

  // ---------------- scale to whole units ----------------
  logic o1_kind_r;
  logic o1_neg_r;
  mag_t o1_mag_r;

  always_ff @(posedge clk) begin
    if (en[ST_O1]) begin
      o1_kind_r <= st_kind[NSTEP];
      o1_neg_r  <= st_acc[NSTEP][ACC_W-1];
      o1_mag_r  <= st_acc[NSTEP][ACC_W-1] ? MAG_W'(-st_acc[NSTEP]) : MAG_W'(st_acc[NSTEP]);
    end
  end

  logic                  o2_kind_r;
  logic                  o2_neg_r;
  logic [RW-1:0]         o2_r_r;
  logic [FRAC_BITS+9:0]  o2_frs;
  logic [RW-1:0]         o2_r_nxt;

  // integer part * 1000 plus rounded fraction * 1000
  assign o2_frs   = ({10'd0, o1_mag_r[FRAC_BITS-1:0]} * (FRAC_BITS+10)'(UNIT_SCALE))
                  + ((FRAC_BITS+10)'(1) << (FRAC_BITS - 1));
  assign o2_r_nxt = RW'(o1_mag_r[MAG_W-1:FRAC_BITS]) * RW'(UNIT_SCALE)
                  + RW'(o2_frs[FRAC_BITS+9:FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (en[ST_O2]) begin
      o2_kind_r <= o1_kind_r;
      o2_neg_r  <= o1_neg_r;
      o2_r_r    <= o2_r_nxt;
    end
  end

  // ---------------- floor, saturate, output register ----------------
  logic [VALUE_W-1:0] out_value_r;
  logic               out_sat_r;
  logic [VALUE_W-1:0] out_value_nxt;
  logic               out_sat_nxt;
  logic               use_floor;

  assign use_floor = (o2_kind_r == REQ_RHO) && (o2_neg_r || (o2_r_r < RW'(cfg_floor_r)));

  always_comb begin
    priority if (use_floor) begin
      out_value_nxt = VALUE_W'(cfg_floor_r);
      out_sat_nxt   = 1'b0;
    end else if (!o2_neg_r && (o2_r_r > RW'(VALUE_MAX))) begin
      out_value_nxt = VALUE_MAX;
      out_sat_nxt   = 1'b1;
    end else if (o2_neg_r && (o2_r_r > RW'(VALUE_MIN))) begin
      out_value_nxt = VALUE_MIN;
      out_sat_nxt   = 1'b1;
    end else begin
      out_value_nxt = o2_neg_r ? -o2_r_r[VALUE_W-1:0] : o2_r_r[VALUE_W-1:0];
      out_sat_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_O3]) begin
      out_value_r <= out_value_nxt;
      out_sat_r   <= out_sat_nxt;
    end
  end

  assign out_ch.valid     = v_r[ST_O3];
  assign out_ch.value     = $signed(out_value_r);
  assign out_ch.saturated = out_sat_r;

endmodule

`default_nettype wire

FILE: tb/sv/seismic_velocity_density_convert_tb.sv
// Self-checking testbench for seismic_velocity_density_convert: directed and random transfers,
// bursty sender, stalling receiver, fixed-point predictor in a small scoreboard class.
// Depends on svdc_pkg, the svdc_in_if/svdc_out_if interfaces and the converter RTL.

module seismic_velocity_density_convert_tb;
  import svdc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_Q        = FRAC_BITS_DEF;
  localparam int VEL_W         = VEL_BITS_DEF;
  localparam int PHASE_ITEMS   = 365;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 200;

  localparam longint          ACC_LIMIT   = 64'sh2000_0000_0000_0000;
  localparam longint unsigned ACC_LIMIT_U = 64'h2000_0000_0000_0000;

  // Horner coefficients in millionths, leading term first
  localparam longint unsigned VP_COEF_MICRO [5] =
    '{64'd25100, 64'd268300, 64'd820600, 64'd2094700, 64'd940900};
  localparam longint unsigned RHO_COEF_MICRO [5] =
    '{64'd106, 64'd4300, 64'd67100, 64'd472100, 64'd1661200};

  localparam int DIRECTED_VEL [12] =
    '{0, 1, 500, 1000, 2500, 4000, 6500, 8191, 8192, 10922, 5461, 16383};

  typedef struct {
    logic               req_type;
    logic [VEL_W-1:0]   velocity;
    logic signed [15:0] value;
    logic               saturated;
  } conv_item_t;

  class conversion_scoreboard;
    conv_item_t         pending[$];
    logic [FLOOR_W-1:0] density_floor;
    int unsigned        mismatches;

    function new();
      density_floor = FLOOR_RST;
      mismatches    = 0;
    endfunction

    function longint clamp_acc(longint v);
      if (v > ACC_LIMIT) return ACC_LIMIT;
      if (v < -ACC_LIMIT) return -ACC_LIMIT;
      return v;
    endfunction

    function longint coef_fixed(longint unsigned micro);
      coef_fixed = ((micro << FRAC_Q) + 64'd500000) / 64'd1000000;
    endfunction

    // magnitude product, shifted with round half away from zero, sign applied after
    function longint fixed_mul(longint a, longint b);
      logic            neg;
      longint unsigned ua, ub, m;
      logic [127:0]    prod;
      neg  = (a < 0) != (b < 0);
      ua   = (a < 0) ? -a : a;
      ub   = (b < 0) ? -b : b;
      prod = {64'd0, ua} * {64'd0, ub};
      if (prod[127:64] != 0) begin
        m = ACC_LIMIT_U;
      end else begin
        m = (prod[63:0] >> FRAC_Q) + ((prod[63:0] >> (FRAC_Q - 1)) & 64'd1);
        if (m > ACC_LIMIT_U) m = ACC_LIMIT_U;
      end
      return neg ? -$signed(m) : $signed(m);
    endfunction

    function longint to_whole_units(longint acc);
      longint unsigned m, ip, fr, r;
      m  = (acc < 0) ? -acc : acc;
      ip = m >> FRAC_Q;
      fr = m & ((64'd1 << FRAC_Q) - 64'd1);
      r  = ip * 64'd1000 + ((fr * 64'd1000 + (64'd1 << (FRAC_Q - 1))) >> FRAC_Q);
      return (acc < 0) ? -$signed(r) : $signed(r);
    endfunction

    function conv_item_t convert_velocity(logic req_type, logic [VEL_W-1:0] velocity);
      longint unsigned vel_u;
      longint          x, acc, y, floor_val;
      conv_item_t      item;
      vel_u = velocity;
      x     = ((vel_u << FRAC_Q) + 64'd500) / 64'd1000;
      if (req_type == REQ_VP) begin
        acc = coef_fixed(VP_COEF_MICRO[0]);
        for (int i = 1; i < 4; i++)
          acc = clamp_acc(coef_fixed(VP_COEF_MICRO[i]) - fixed_mul(x, acc));
        acc = clamp_acc(coef_fixed(VP_COEF_MICRO[4]) + fixed_mul(x, acc));
        y   = to_whole_units(acc);
      end else begin
        acc = coef_fixed(RHO_COEF_MICRO[0]);
        for (int i = 1; i < 5; i++)
          acc = clamp_acc(coef_fixed(RHO_COEF_MICRO[i]) - fixed_mul(x, acc));
        acc       = fixed_mul(x, acc);
        y         = to_whole_units(acc);
        floor_val = density_floor;
        // floor does not count as saturation
        if (y < floor_val) y = floor_val;
      end
      item.req_type  = req_type;
      item.velocity  = velocity;
      item.saturated = 1'b0;
      if (y > 32767) begin
        y = 32767;
        item.saturated = 1'b1;
      end
      if (y < -32768) begin
        y = -32768;
        item.saturated = 1'b1;
      end
      item.value = y[15:0];
      return item;
    endfunction

    function void note_transfer(logic req_type, logic [VEL_W-1:0] velocity);
      pending.push_back(convert_velocity(req_type, velocity));
    endfunction

    function void check_result(logic signed [15:0] value, logic saturated);
      conv_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual value %0d saturated %0b",
                 $time, value, saturated);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (value !== want.value) begin
        $display("%0t: value (req %0d vel %0d): expected %0d, actual %0d",
                 $time, want.req_type, want.velocity, want.value, value);
        mismatches++;
      end
      if (saturated !== want.saturated) begin
        $display("%0t: saturated (req %0d vel %0d): expected %0b, actual %0b",
                 $time, want.req_type, want.velocity, want.saturated, saturated);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [FLOOR_W-1:0] cfg_wdata;

  svdc_in_if  in_ch();
  svdc_out_if out_ch();

  seismic_velocity_density_convert dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  conversion_scoreboard board = new();
  int unsigned          burst_left = 0;
  int unsigned          cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // called at a rising edge; returns at the edge of the transfer with valid still high
  task automatic send_item(input logic req_type, input logic [VEL_W-1:0] velocity);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req_type;
    in_ch.velocity <= velocity;
    do @(posedge clk); while (!in_ch.ready);
    board.note_transfer(req_type, velocity);
    burst_left--;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_density_floor(input logic [FLOOR_W-1:0] floor_value);
    cfg_wdata <= floor_value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.density_floor = floor_value;
  endtask

  function automatic logic [VEL_W-1:0] pick_velocity();
    case ($urandom_range(0, 9))
      0:             return ($urandom_range(0, 1) == 0) ? VEL_W'($urandom_range(0, 15))
                                                        : VEL_W'(16383 - $urandom_range(0, 15));
      1, 2, 3, 4, 5: return VEL_W'($urandom_range(0, 9000));
      default:       return VEL_W'($urandom_range(0, 16383));
    endcase
  endfunction

  initial begin : stimulus
    logic [FLOOR_W-1:0] floor_plan [5];
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= REQ_VP;
    in_ch.velocity <= '0;
    floor_plan = '{12'd0, 12'd4095, 12'd4000, 12'(($urandom_range(1, 3999))), 12'd1000};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // both operations at the field extremes, bit patterns and around the floor, reset floor
    foreach (DIRECTED_VEL[i]) begin
      send_item(REQ_VP, VEL_W'(DIRECTED_VEL[i]));
      send_item(REQ_RHO, VEL_W'(DIRECTED_VEL[i]));
    end

    foreach (floor_plan[p]) begin
      wait_idle();
      write_density_floor(floor_plan[p]);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_item($urandom_range(0, 1) ? REQ_RHO : REQ_VP, pick_velocity());
    end

    wait_idle();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("seismic_velocity_density_convert_tb OK");
    end else begin
      $display("seismic_velocity_density_convert_tb NOT OK");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned hold_left, results_seen, mode, mode_left, pattern_cnt;
    hold_left    = 0;
    results_seen = 0;
    mode         = 0;
    mode_left    = 0;
    pattern_cnt  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        board.check_result(out_ch.value, out_ch.saturated);
        results_seen++;
        // long hold-off while the sender keeps going, so the pipeline backs up
        if (results_seen == 400 || results_seen == 1300) hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      pattern_cnt++;
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ((pattern_cnt % 7) < 4);
        endcase
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("seismic_velocity_density_convert_tb NOT OK");
    $finish;
  end

endmodule
